@@ design/focc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FOC current controller package
// Shared constants, step codes, register indexes and the quarter-wave sine
// table used by the controller and the datapath.
// ----------------------------------------------------------------------------
package focc_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 8;
   localparam int ANGLE_STEPS           = 1024;
   localparam int ANGLE_BITS            = $clog2(ANGLE_STEPS);
   localparam int QUARTER               = ANGLE_STEPS / 4;
   localparam int FRACTION_BITS         = 8;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam int INV_SQRT3_Q16 = 37837;
   localparam int KI_Q16        = 6554;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_ANGLE_OFFSET     = 3'd0,
      CSR_POLE_PAIRS       = 3'd1,
      CSR_PHASE_U_OFFSET   = 3'd2,
      CSR_PHASE_W_OFFSET   = 3'd3,
      CSR_Q_INTEGRAL_LIMIT = 3'd4,
      CSR_D_INTEGRAL_LIMIT = 3'd5,
      CSR_Q_VOLTAGE_LIMIT  = 3'd6
   } csr_index_type;

   // Datapath steps, one per cycle after an item is taken.
   typedef enum logic [3:0] {
      STEP_ANG = 4'd0,
      STEP_SIN = 4'd1,
      STEP_COS = 4'd2,
      STEP_M1  = 4'd3,
      STEP_M2  = 4'd4,
      STEP_M3  = 4'd5,
      STEP_M4  = 4'd6,
      STEP_M5  = 4'd7,
      STEP_M6  = 4'd8,
      STEP_M7  = 4'd9,
      STEP_M8  = 4'd10,
      STEP_M9  = 4'd11,
      STEP_M10 = 4'd12,
      STEP_M11 = 4'd13,
      STEP_M12 = 4'd14
   } step_type;

   typedef struct packed {
      logic     load;
      logic     run;
      step_type step;
      logic     out_load;
   } cmd_type;

   typedef logic [15:0] sine_table_type [0:QUARTER];

   // Shift-and-subtract quotient, used only while the table is built.
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Builds the first quadrant of the sine table from a Q2.30 Taylor sum.
   function automatic sine_table_type build_sine();
      sine_table_type tbl;
      longint unsigned x;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned k64;
      for (int k = 0; k <= QUARTER; k++) begin
         k64  = longint'(k);
         x    = (k64 * TWO_PI_Q30 + longint'(ANGLE_STEPS / 2)) >> ANGLE_BITS;
         term = x;
         sum  = x;
         for (int i = 1; i <= 7; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_u64(term, 64'((2 * i) * (2 * i + 1)));
            if ((i & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sum = (sum + 64'd16384) >> 15;
         if (sum > 64'd32767) begin
            sum = 64'd32767;
         end
         tbl[k] = sum[15:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

   // Full-circle sine in Q1.15 from the quarter-wave table.
   function automatic logic signed [16:0] sine_lookup(input logic [ANGLE_BITS-1:0] k);
      logic                  neg;
      logic [ANGLE_BITS-1:0] half;
      logic [ANGLE_BITS-1:0] idx;
      logic [16:0]           mag;
      neg  = k[ANGLE_BITS-1];
      half = {1'b0, k[ANGLE_BITS-2:0]};
      if (half > ANGLE_BITS'(QUARTER)) begin
         idx = ANGLE_BITS'(2 * QUARTER) - half;
      end else begin
         idx = half;
      end
      mag = {1'b0, SINE_TABLE[idx[ANGLE_BITS-2:0]]};
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [15:0] sat_16(input logic signed [47:0] v);
      if (v > 48'sd32767) begin
         return 16'sh7fff;
      end else if (v < -48'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [17:0] sat_18(input logic signed [47:0] v);
      if (v > 48'sd131071) begin
         return 18'sh1ffff;
      end else if (v < -48'sd131072) begin
         return 18'sh20000;
      end
      return v[17:0];
   endfunction

endpackage

@@ design/focc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FOC current controller sequencer
// Takes an item when idle, steps the datapath through its schedule and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module focc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output focc_pkg::cmd_type cmd
);
   import focc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   step_type  step_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.run      = (state_ff == ST_RUN);
      cmd.step     = step_ff;
      cmd.out_load = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_ANG;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               step_ff <= STEP_ANG;
               if (req_valid) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (step_ff == STEP_M12) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff <= step_type'(4'(step_ff) + 4'd1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A new result appears only once the last step has completed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised without finishing the schedule");

   // A waiting result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   // The schedule always starts at its first step.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_RUN) && (step_ff == STEP_ANG))
      else $error("schedule did not start at the first step");

endmodule

@@ design/focc_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FOC current controller datapath
// Position ring, angle and sine lookup, one shared multiplier for the
// Clarke, Park, PI and inverse Park products, configuration registers and
// the result register.
// ----------------------------------------------------------------------------
module focc_dpath #(
   parameter int HISTORY_DEPTH = focc_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  focc_pkg::cmd_type  cmd,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic [9:0]         req_encoder_position,
   input  logic [11:0]        req_phase_u_sample,
   input  logic [11:0]        req_phase_w_sample,
   input  logic signed [15:0] req_q_target,
   input  logic signed [15:0] req_d_target,
   output logic signed [15:0] rsp_drive_a,
   output logic signed [15:0] rsp_drive_b,
   output logic signed [15:0] rsp_q_measured,
   output logic signed [15:0] rsp_d_measured,
   output logic signed [17:0] rsp_q_voltage,
   output logic signed [17:0] rsp_d_voltage
);
   import focc_pkg::*;

   localparam int IDX_BITS = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // Configuration registers.
   logic [9:0]  angle_offset_ff;
   logic [3:0]  pole_pairs_ff;
   logic [11:0] phase_u_offset_ff;
   logic [11:0] phase_w_offset_ff;
   logic [15:0] q_integral_limit_ff;
   logic [15:0] d_integral_limit_ff;
   logic [14:0] q_voltage_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_offset_ff     <= 10'd98;
         pole_pairs_ff       <= 4'd7;
         phase_u_offset_ff   <= 12'd2044;
         phase_w_offset_ff   <= 12'd2061;
         q_integral_limit_ff <= 16'd50000;
         d_integral_limit_ff <= 16'd20000;
         q_voltage_limit_ff  <= 15'd4700;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANGLE_OFFSET:     angle_offset_ff     <= csr_data[9:0];
            CSR_POLE_PAIRS:       pole_pairs_ff       <= csr_data[3:0];
            CSR_PHASE_U_OFFSET:   phase_u_offset_ff   <= csr_data[11:0];
            CSR_PHASE_W_OFFSET:   phase_w_offset_ff   <= csr_data[11:0];
            CSR_Q_INTEGRAL_LIMIT: q_integral_limit_ff <= csr_data;
            CSR_D_INTEGRAL_LIMIT: d_integral_limit_ff <= csr_data;
            CSR_Q_VOLTAGE_LIMIT:  q_voltage_limit_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Position ring; entries not yet written read as zero.
   logic [9:0]              hist_mem [0:HISTORY_DEPTH-1];
   logic [HISTORY_DEPTH-1:0] hist_valid_ff;
   logic [IDX_BITS-1:0]     hist_idx_ff;
   logic [9:0]              last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hist_mem[hist_idx_ff] <= req_encoder_position;
         last_ff <= hist_valid_ff[hist_idx_ff] ? hist_mem[hist_idx_ff] : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         hist_idx_ff   <= '0;
      end else if (cmd.load) begin
         hist_valid_ff[hist_idx_ff] <= 1'b1;
         if (hist_idx_ff == IDX_BITS'(HISTORY_DEPTH - 1)) begin
            hist_idx_ff <= '0;
         end else begin
            hist_idx_ff <= hist_idx_ff + 1'b1;
         end
      end
   end

   // Item registers.
   logic [9:0]         pos_ff;
   logic signed [15:0] qt_ff;
   logic signed [15:0] dt_ff;
   logic signed [12:0] i1_ff;
   logic signed [12:0] i2_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff <= req_encoder_position;
         qt_ff  <= req_q_target;
         dt_ff  <= req_d_target;
         i1_ff  <= $signed({1'b0, req_phase_u_sample}) - $signed({1'b0, phase_u_offset_ff});
         i2_ff  <= $signed({1'b0, req_phase_w_sample}) - $signed({1'b0, phase_w_offset_ff});
      end
   end

   // Angle: the mod is the low bits of the two's complement product.
   logic signed [12:0]   ext;
   logic signed [17:0]   ang_prod;
   logic [ANGLE_BITS-1:0] ang_ff;

   assign ext      = $signed({2'b00, pos_ff, 1'b0}) - $signed({3'b000, last_ff});
   assign ang_prod = $signed({1'b0, pole_pairs_ff}) * ext;

   // Working registers.
   logic signed [16:0] s_ff;
   logic signed [16:0] c_ff;
   logic signed [23:0] ib_ff;
   logic signed [26:0] iq_ff;
   logic signed [26:0] id_ff;
   logic signed [25:0] q_int_ff;
   logic signed [25:0] d_int_ff;
   logic signed [27:0] uq_ff;
   logic signed [27:0] ud_ff;
   logic signed [15:0] ua_ff;
   logic signed [15:0] ub_ff;
   logic signed [45:0] prod_ff;
   logic signed [45:0] acc_ff;

   logic signed [14:0] i_sum;
   logic signed [20:0] ia;
   logic signed [17:0] mul_a;
   logic signed [27:0] mul_b;
   logic signed [46:0] acc_add;
   logic signed [46:0] acc_sub;
   logic signed [27:0] eq;
   logic signed [27:0] ed;
   logic signed [27:0] ki_term;
   logic signed [28:0] q_int_sum;
   logic signed [28:0] d_int_sum;
   logic signed [28:0] q_int_lim;
   logic signed [28:0] d_int_lim;
   logic signed [27:0] uq_lim;
   logic signed [27:0] uq_clamped;
   logic signed [25:0] q_int_in;
   logic signed [25:0] d_int_in;

   assign i_sum   = $signed({{2{i1_ff[12]}}, i1_ff}) + $signed({i2_ff[12], i2_ff, 1'b0});
   assign ia      = $signed({i1_ff, 8'b0});
   assign acc_add = 47'(acc_ff) + 47'(prod_ff);
   assign acc_sub = 47'(acc_ff) - 47'(prod_ff);
   assign eq      = 28'($signed({qt_ff, 8'b0})) - 28'(iq_ff);
   assign ed      = 28'($signed({dt_ff, 8'b0})) - 28'(id_ff);
   assign ki_term = 28'((prod_ff + 46'sd32768) >>> 16);

   assign q_int_sum = 29'(q_int_ff) + 29'(eq);
   assign d_int_sum = 29'(d_int_ff) + 29'(ed);
   assign q_int_lim = $signed({5'b0, q_integral_limit_ff, 8'b0});
   assign d_int_lim = $signed({5'b0, d_integral_limit_ff, 8'b0});
   assign uq_lim    = $signed({5'b0, q_voltage_limit_ff, 8'b0});

   always_comb begin
      if (q_int_sum > q_int_lim) begin
         q_int_in = 26'(q_int_lim);
      end else if (q_int_sum < -q_int_lim) begin
         q_int_in = 26'(-q_int_lim);
      end else begin
         q_int_in = 26'(q_int_sum);
      end
      if (d_int_sum > d_int_lim) begin
         d_int_in = 26'(d_int_lim);
      end else if (d_int_sum < -d_int_lim) begin
         d_int_in = 26'(-d_int_lim);
      end else begin
         d_int_in = 26'(d_int_sum);
      end
      if (uq_ff > uq_lim) begin
         uq_clamped = uq_lim;
      end else if (uq_ff < -uq_lim) begin
         uq_clamped = -uq_lim;
      end else begin
         uq_clamped = uq_ff;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_SIN: begin
            mul_a = 18'(INV_SQRT3_Q16);
            mul_b = 28'(i_sum);
         end
         STEP_M1: begin
            mul_a = 18'(c_ff);
            mul_b = 28'(ia);
         end
         STEP_M2: begin
            mul_a = 18'(s_ff);
            mul_b = 28'(ib_ff);
         end
         STEP_M3: begin
            mul_a = 18'(s_ff);
            mul_b = 28'(ia);
         end
         STEP_M4: begin
            mul_a = 18'(c_ff);
            mul_b = 28'(ib_ff);
         end
         STEP_M5: begin
            mul_a = 18'(KI_Q16);
            mul_b = 28'(q_int_ff);
         end
         STEP_M6: begin
            mul_a = 18'(KI_Q16);
            mul_b = 28'(d_int_ff);
         end
         STEP_M8: begin
            mul_a = 18'(c_ff);
            mul_b = uq_clamped;
         end
         STEP_M9: begin
            mul_a = 18'(s_ff);
            mul_b = ud_ff;
         end
         STEP_M10: begin
            mul_a = 18'(s_ff);
            mul_b = uq_clamped;
         end
         STEP_M11: begin
            mul_a = 18'(c_ff);
            mul_b = ud_ff;
         end
         default: ;
      endcase
   end

   // Division by 2^(15+F) truncating toward zero.
   function automatic logic signed [15:0] drive_out(input logic signed [46:0] v);
      logic signed [46:0] biased;
      biased = v[46] ? v + 47'sd8388607 : v;
      return sat_16(48'(biased >>> 23));
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.run) begin
         prod_ff <= mul_a * mul_b;
         case (cmd.step)
            STEP_ANG: ang_ff <= ang_prod[ANGLE_BITS-1:0] + angle_offset_ff;
            STEP_SIN: s_ff <= sine_lookup(ang_ff);
            STEP_COS: begin
               c_ff  <= sine_lookup(ang_ff + ANGLE_BITS'(QUARTER));
               ib_ff <= 24'((prod_ff + 46'sd128) >>> 8);
            end
            STEP_M2:  acc_ff <= prod_ff;
            STEP_M3:  iq_ff <= 27'((acc_sub + 47'sd16384) >>> 15);
            STEP_M4:  acc_ff <= prod_ff;
            STEP_M5:  id_ff <= 27'((acc_add + 47'sd16384) >>> 15);
            STEP_M6:  uq_ff <= eq + ki_term;
            STEP_M7:  ud_ff <= ed + ki_term;
            STEP_M9:  acc_ff <= prod_ff;
            STEP_M10: ua_ff <= drive_out(acc_add);
            STEP_M11: acc_ff <= prod_ff;
            STEP_M12: ub_ff <= drive_out(acc_sub);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_int_ff <= '0;
         d_int_ff <= '0;
      end else if (cmd.run) begin
         if (cmd.step == STEP_M6) begin
            q_int_ff <= q_int_in;
         end
         if (cmd.step == STEP_M7) begin
            d_int_ff <= d_int_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_drive_a    <= ua_ff;
         rsp_drive_b    <= ub_ff;
         rsp_q_measured <= sat_16(48'((iq_ff + 27'sd128) >>> 8));
         rsp_d_measured <= sat_16(48'((id_ff + 27'sd128) >>> 8));
         rsp_q_voltage  <= sat_18(48'((uq_ff + 28'sd128) >>> 8));
         rsp_d_voltage  <= sat_18(48'((ud_ff + 28'sd128) >>> 8));
      end
   end

   // Integrators stay inside their limits.
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.run && cmd.step == STEP_M6) |->
         (29'(q_int_ff) <= q_int_lim) && (29'(q_int_ff) >= -q_int_lim))
      else $error("q integrator outside its limit");

   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.run && cmd.step == STEP_M7) |->
         (29'(d_int_ff) <= d_int_lim) && (29'(d_int_ff) >= -d_int_lim))
      else $error("d integrator outside its limit");

   // The ring pointer moves only when an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      !cmd.load |=> $stable(hist_idx_ff))
      else $error("ring pointer moved without an item");

endmodule

@@ design/foc_current_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FOC current controller
// Field-oriented current loop: position extrapolation, Clarke and Park
// transforms, two PI regulators and an inverse Park transform per item.
//
//   Channel  Prefix  Handshake        Contents
//   input    req_    valid / stall    position, two phase samples, q/d targets
//   result   rsp_    valid / stall    two drive values, currents, voltages
//   config   csr_    valid / ready    register index and write data
//
// A result follows its item through fifteen steps of the single shared
// multiplier and the output load. The next item can be taken in the cycle
// after the output load; none is taken while an item is in progress.
// A new item is taken while the previous result waits in the output register.
// Reset is synchronous; it clears the position ring, integrators and rsp_valid.
// If that result is still stalled when the next item finishes, the sequencer
// holds the new result until the old one is taken.
// ----------------------------------------------------------------------------
module foc_current_controller_top #(
   parameter int HISTORY_DEPTH = focc_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [9:0]         req_encoder_position,
   input  logic [11:0]        req_phase_u_sample,
   input  logic [11:0]        req_phase_w_sample,
   input  logic signed [15:0] req_q_target,
   input  logic signed [15:0] req_d_target,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_drive_a,
   output logic signed [15:0] rsp_drive_b,
   output logic signed [15:0] rsp_q_measured,
   output logic signed [15:0] rsp_d_measured,
   output logic signed [17:0] rsp_q_voltage,
   output logic signed [17:0] rsp_d_voltage,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import focc_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   focc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   focc_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_encoder_position (req_encoder_position),
      .req_phase_u_sample   (req_phase_u_sample),
      .req_phase_w_sample   (req_phase_w_sample),
      .req_q_target         (req_q_target),
      .req_d_target         (req_d_target),
      .rsp_drive_a          (rsp_drive_a),
      .rsp_drive_b          (rsp_drive_b),
      .rsp_q_measured       (rsp_q_measured),
      .rsp_d_measured       (rsp_d_measured),
      .rsp_q_voltage        (rsp_q_voltage),
      .rsp_d_voltage        (rsp_d_voltage)
   );

endmodule
